// ===== rtl/core/cse_pkg.sv =====
// shared constants, types and log table arithmetic for the column entropy block
`timescale 1ns / 1ps

package cse_pkg;

  // default sizes
  localparam int DEF_MAX_COLUMNS   = 64;
  localparam int DEF_MAX_ROWS      = 1024;
  localparam int DEF_ALPHABET_SIZE = 256;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int NUM_SEQ_W   = 11;
  localparam int SEQ_LEN_W   = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_NUM_SEQUENCES   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEQUENCE_LENGTH = 1'd1;

  localparam logic [NUM_SEQ_W-1:0] NUM_SEQ_RESET = 11'd1;
  localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RESET = 7'd64;

  // payload widths
  localparam int SYMBOL_W   = 8;
  localparam int POSITION_W = 6;
  localparam int ENTROPY_W  = 15;
  localparam int LOG_W      = 16;

  localparam logic [ENTROPY_W-1:0] ENTROPY_MAX = '1;

  // histogram memory operation
  typedef struct packed {
    logic inc;
    logic clr;
  } hist_op_t;

  // (a*b) >> 62 for a, b below 2^62
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [63:0] ah;
    logic [63:0] al;
    logic [63:0] bh;
    logic [63:0] bl;
    logic [63:0] mid;
    ah  = a >> 31;
    al  = a & 64'h0000_0000_7FFF_FFFF;
    bh  = b >> 31;
    bl  = b & 64'h0000_0000_7FFF_FFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 31);
    return ah * bh + (mid >> 31);
  endfunction

  // bitwise long division, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // 2*atanh(num/den) in q62 by odd power series
  function automatic logic [63:0] two_atanh_q62(logic [63:0] num, logic [63:0] den);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] sum;
    z   = udiv64(num << 52, den) << 10;
    z2  = mul_q62(z, z);
    p   = z;
    sum = '0;
    for (int j = 0; j < 48; j++) begin
      if (p != 64'd0) begin
        sum = sum + udiv64(p, 64'(2 * j + 1));
        p   = mul_q62(p, z2);
      end
    end
    return sum << 1;
  endfunction

  // round(ln(i) * 4096), zero for i of zero
  function automatic logic [LOG_W-1:0] ln_q12(int i);
    logic [63:0] iv;
    logic [63:0] ln2_q50;
    logic [63:0] p2;
    logic [63:0] total;
    int k;
    if (i == 0) begin
      return '0;
    end
    iv      = 64'(i);
    ln2_q50 = two_atanh_q62(64'd1, 64'd3) >> 12;
    k       = 0;
    for (int t = 0; t < 31; t++) begin
      if ((64'd2 << k) <= iv) begin
        k++;
      end
    end
    p2    = 64'd1 << k;
    total = 64'(k) * ln2_q50 + (two_atanh_q62(iv - p2, iv + p2) >> 12);
    return LOG_W'((total + (64'd1 << 37)) >> 38);
  endfunction

endpackage

// ===== rtl/core/cse_ifs.sv =====
// request channels: symbol input and column result output
`timescale 1ns / 1ps

interface cse_sym_if;
  logic                         valid;
  logic                         ready;
  logic [cse_pkg::SYMBOL_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink (input valid, input symbol, output ready);
endinterface

interface cse_res_if;
  logic                           valid;
  logic                           ready;
  logic [cse_pkg::POSITION_W-1:0] position;
  logic [cse_pkg::ENTROPY_W-1:0]  entropy;
  logic                           last_result;

  modport source (output valid, output position, output entropy, output last_result,
                  input ready);
  modport sink (input valid, input position, input entropy, input last_result,
                output ready);
endinterface

// ===== rtl/core/column_symbol_entropy_top.sv =====
// column entropy top: symbol histogram per column, entropy walk per batch
// loading takes one symbol per cycle, one histogram read-modify-write each
// after the last symbol a settle state, then each column runs a bin scan, a product drain,
// a bit-serial divide and an emit that waits out any result stall
// reset and every register write start a clearing pass over all
// MAX_COLUMNS*ALPHABET_SIZE histogram entries with the symbol input not ready
`timescale 1ns / 1ps

module column_symbol_entropy_top #(
  parameter int MAX_COLUMNS   = cse_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS      = cse_pkg::DEF_MAX_ROWS,
  parameter int ALPHABET_SIZE = cse_pkg::DEF_ALPHABET_SIZE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cse_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cse_pkg::CFG_DATA_W-1:0]  cfg_data,
  cse_sym_if.sink                         symbols,
  cse_res_if.source                       results
);

  localparam int DEPTH  = MAX_COLUMNS * ALPHABET_SIZE;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_ROWS + 1);
  localparam int CI_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CL_W   = $clog2(MAX_COLUMNS + 1);
  localparam int SYM_W  = $clog2(ALPHABET_SIZE);
  localparam int ACC_W  = CW + cse_pkg::LOG_W;
  localparam int DVD_W  = ACC_W + 1;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_SETTLE = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_DIVIDE = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0]                       state;
  logic [cse_pkg::NUM_SEQ_W-1:0]    num_sequences;
  logic [cse_pkg::SEQ_LEN_W-1:0]    sequence_length;
  logic [AW-1:0]                    clr_addr;
  logic [CI_W-1:0]                  col;
  logic [CW-1:0]                    row;
  logic [SYM_W-1:0]                 bin;
  logic                             v1;
  logic                             v2;
  logic                             v3;
  logic [CW-1:0]                    c2;
  logic [ACC_W-1:0]                 prod;
  logic [ACC_W-1:0]                 acc;
  logic [cse_pkg::POSITION_W-1:0]   res_position;
  logic [cse_pkg::ENTROPY_W-1:0]    res_entropy;
  logic                             res_last;

  logic [CW-1:0]                    n_eff;
  logic [CL_W-1:0]                  cols_eff;
  logic [SYM_W-1:0]                 sym_c;
  logic                             accept;
  logic                             last_col;
  logic                             last_row;
  logic                             drained;
  logic [AW-1:0]                    col_base;
  cse_pkg::hist_op_t                hop;
  logic [AW-1:0]                    haddr;
  logic [CW-1:0]                    hist_count;
  logic [cse_pkg::LOG_W-1:0]        log_c;
  logic [cse_pkg::LOG_W-1:0]        ln_n;
  logic                             div_start;
  logic                             div_done;
  logic [DVD_W-1:0]                 quotient;
  logic [cse_pkg::LOG_W-1:0]        ent_diff;
  logic [cse_pkg::ENTROPY_W-1:0]    ent_val;

  // effective row and column counts
  always_comb begin
    if (num_sequences == '0) begin
      n_eff = CW'(1);
    end else if (32'(num_sequences) > MAX_ROWS) begin
      n_eff = CW'(MAX_ROWS);
    end else begin
      n_eff = CW'(num_sequences);
    end
    if (sequence_length == '0) begin
      cols_eff = CL_W'(1);
    end else if (32'(sequence_length) > MAX_COLUMNS) begin
      cols_eff = CL_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CL_W'(sequence_length);
    end
  end

  // symbols past the alphabet land in the last bin
  assign sym_c = (32'(symbols.symbol) >= ALPHABET_SIZE) ? SYM_W'(ALPHABET_SIZE - 1)
                                                       : SYM_W'(symbols.symbol);

  assign symbols.ready = (state == ST_LOAD);
  assign accept        = symbols.valid && symbols.ready;
  assign last_col      = (CL_W'(col) == cols_eff - CL_W'(1));
  assign last_row      = (row == n_eff - CW'(1));
  assign drained       = !v1 && !v2 && !v3;
  assign col_base      = AW'(col) * AW'(ALPHABET_SIZE);

  // histogram memory access per state
  always_comb begin
    hop   = '0;
    haddr = '0;
    case (state)
      ST_CLEAR: begin
        hop.clr = 1'b1;
        haddr   = clr_addr;
      end
      ST_LOAD: begin
        hop.inc = accept;
        haddr   = col_base + AW'(sym_c);
      end
      ST_SCAN: begin
        hop.clr = 1'b1;
        haddr   = col_base + AW'(bin);
      end
      default: begin
        hop   = '0;
        haddr = '0;
      end
    endcase
  end

  cse_hist #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROWS      (MAX_ROWS),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_hist (
    .clk   (clk),
    .rst   (rst),
    .op    (hop),
    .addr  (haddr),
    .count (hist_count)
  );

  cse_log_rom #(
    .MAX_ROWS (MAX_ROWS)
  ) u_log_rom (
    .clk    (clk),
    .addr_a (hist_count),
    .addr_b (n_eff),
    .data_a (log_c),
    .data_b (ln_n)
  );

  // control: counters and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      num_sequences   <= cse_pkg::NUM_SEQ_RESET;
      sequence_length <= cse_pkg::SEQ_LEN_RESET;
      clr_addr        <= '0;
      col             <= '0;
      row             <= '0;
      bin             <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cse_pkg::REG_NUM_SEQUENCES: begin
          num_sequences <= cfg_data[cse_pkg::NUM_SEQ_W-1:0];
        end
        cse_pkg::REG_SEQUENCE_LENGTH: begin
          sequence_length <= cfg_data[cse_pkg::SEQ_LEN_W-1:0];
        end
        default: begin
          num_sequences <= num_sequences;
        end
      endcase
      state    <= ST_CLEAR;
      clr_addr <= '0;
      col      <= '0;
      row      <= '0;
      bin      <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_LOAD;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        ST_LOAD: begin
          if (accept) begin
            if (last_col) begin
              col <= '0;
              if (last_row) begin
                row   <= '0;
                state <= ST_SETTLE;
              end else begin
                row <= row + CW'(1);
              end
            end else begin
              col <= col + CI_W'(1);
            end
          end
        end
        ST_SETTLE: begin
          bin   <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (bin == SYM_W'(ALPHABET_SIZE - 1)) begin
            state <= ST_DRAIN;
          end else begin
            bin <= bin + SYM_W'(1);
          end
        end
        ST_DRAIN: begin
          if (drained) begin
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (results.ready) begin
            bin <= '0;
            if (res_last) begin
              col   <= '0;
              state <= ST_LOAD;
            end else begin
              col   <= col + CI_W'(1);
              state <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // scan pipeline valids: count, log value, product
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= (state == ST_SCAN);
      v2 <= v1;
      v3 <= v2;
    end
  end

  // c*ln(c) product, registered
  always_ff @(posedge clk) begin
    c2   <= hist_count;
    prod <= ACC_W'(c2) * ACC_W'(log_c);
  end

  // column sum
  always_ff @(posedge clk) begin
    if (state == ST_SETTLE || (state == ST_EMIT && results.ready)) begin
      acc <= '0;
    end else if (v3) begin
      acc <= acc + prod;
    end
  end

  // rounded quotient of sum by row count
  assign div_start = (state == ST_DRAIN) && drained;

  cse_div #(
    .DVD_W (DVD_W),
    .DVS_W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DVD_W'(acc) + DVD_W'(n_eff >> 1)),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // ln(n) minus quotient, clamped to the output range
  always_comb begin
    ent_diff = ln_n - quotient[cse_pkg::LOG_W-1:0];
    if (quotient > DVD_W'(ln_n)) begin
      ent_val = '0;
    end else if (ent_diff > cse_pkg::LOG_W'(cse_pkg::ENTROPY_MAX)) begin
      ent_val = cse_pkg::ENTROPY_MAX;
    end else begin
      ent_val = ent_diff[cse_pkg::ENTROPY_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_DIVIDE && div_done) begin
      res_position <= cse_pkg::POSITION_W'(col);
      res_entropy  <= ent_val;
      res_last     <= last_col;
    end
  end

  assign results.valid       = (state == ST_EMIT);
  assign results.position    = res_position;
  assign results.entropy     = res_entropy;
  assign results.last_result = res_last;

endmodule

// ===== rtl/core/cse_hist.sv =====
// histogram memory with increment pipeline and read-and-clear port
`timescale 1ns / 1ps

module cse_hist #(
  parameter int MAX_COLUMNS   = cse_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS      = cse_pkg::DEF_MAX_ROWS,
  parameter int ALPHABET_SIZE = cse_pkg::DEF_ALPHABET_SIZE,
  localparam int DEPTH = MAX_COLUMNS * ALPHABET_SIZE,
  localparam int AW    = $clog2(DEPTH),
  localparam int CW    = $clog2(MAX_ROWS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  cse_pkg::hist_op_t op,
  input  logic [AW-1:0]     addr,
  output logic [CW-1:0]     count
);

  logic [CW-1:0] mem [DEPTH];
  logic [CW-1:0] rd_q;
  logic          b_valid;
  logic [AW-1:0] b_addr;
  logic          w_valid;
  logic [AW-1:0] w_addr;
  logic [CW-1:0] w_val;
  logic [CW-1:0] inc_val;

  // forward the previous write when it hit the same bin
  assign inc_val = ((w_valid && (w_addr == b_addr)) ? w_val : rd_q) + CW'(1);

  // single memory, read-first, increment written back in the cycle after the read
  always_ff @(posedge clk) begin
    if (op.inc || op.clr) begin
      rd_q <= mem[addr];
    end
    if (b_valid) begin
      mem[b_addr] <= inc_val;
    end else if (op.clr) begin
      mem[addr] <= '0;
    end
  end

  // increment stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      w_valid <= 1'b0;
    end else begin
      b_valid <= op.inc;
      w_valid <= b_valid;
    end
  end

  // increment stage addresses and last written value
  always_ff @(posedge clk) begin
    b_addr <= addr;
    w_addr <= b_addr;
    w_val  <= inc_val;
  end

  assign count = rd_q;

endmodule

// ===== rtl/core/cse_log_rom.sv =====
// dual read port log rom, round(ln(i)*4096) for i up to the row limit
`timescale 1ns / 1ps

module cse_log_rom #(
  parameter int MAX_ROWS = cse_pkg::DEF_MAX_ROWS,
  localparam int CW = $clog2(MAX_ROWS + 1)
) (
  input  logic                      clk,
  input  logic [CW-1:0]             addr_a,
  input  logic [CW-1:0]             addr_b,
  output logic [cse_pkg::LOG_W-1:0] data_a,
  output logic [cse_pkg::LOG_W-1:0] data_b
);

  typedef logic [cse_pkg::LOG_W-1:0] rom_t [MAX_ROWS + 1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= MAX_ROWS; i++) begin
      r[i] = cse_pkg::ln_q12(i);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  // registered reads
  always_ff @(posedge clk) begin
    data_a <= ROM[addr_a];
    data_b <= ROM[addr_b];
  end

endmodule

// ===== rtl/core/cse_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module cse_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 11,
  localparam int STEP_W = $clog2(DVD_W + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DVD_W-1:0]  quo;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              take;

  // trial subtract of the shifted remainder
  assign trial = {rem, quo[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign take  = (trial >= {1'b0, dvs});

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DVD_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], take};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/core/cse_checker.sv =====
// port-level checks for the column entropy top, attached by bind
`timescale 1ns / 1ps

module cse_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic                            sym_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [cse_pkg::POSITION_W-1:0]  res_position,
  input logic [cse_pkg::ENTROPY_W-1:0]   res_entropy,
  input logic                            res_last
);

  // reset leaves both channels quiet while memory clears
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid && !sym_ready)
    else $error("channels active right after reset");

  // a register write restarts with a clearing pass
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !sym_ready && !res_valid)
    else $error("channels active right after register write");

  // loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(res_valid && sym_ready))
    else $error("symbol ready while a result is offered");

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready && !cfg_we |=>
      res_valid && $stable(res_position) && $stable(res_entropy) && $stable(res_last))
    else $error("result changed while stalled");

  // after the last column the next batch can load at once
  a_next_batch: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_last && !cfg_we |=> sym_ready)
    else $error("symbol input not ready after last result");

endmodule

bind column_symbol_entropy_top cse_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_we       (cfg_we),
  .sym_ready    (symbols.ready),
  .res_valid    (results.valid),
  .res_ready    (results.ready),
  .res_position (results.position),
  .res_entropy  (results.entropy),
  .res_last     (results.last_result)
);
